>>> hw/rtl/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared types, constants and helper functions of the turtle interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package tgi_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int ENTRY_COUNT_DEF = 6;

    localparam int ENTRY_W   = 55;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 112;
    localparam int STK_W     = 73;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PW    = 2;
    localparam int CMDQ_CW    = 3;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SAVE    = 3'd1;
    localparam logic [2:0] ACT_RESTORE = 3'd2;
    localparam logic [2:0] ACT_ROTATE  = 3'd3;
    localparam logic [2:0] ACT_CIRCLE  = 3'd4;
    localparam logic [2:0] ACT_DRAW    = 3'd5;
    localparam logic [2:0] ACT_MOVE    = 3'd6;
    localparam logic [2:0] ACT_NONE_HI = 3'd7;

    localparam logic [1:0] KIND_LINE      = 2'd0;
    localparam logic [1:0] KIND_CIRCLE    = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd3;

    localparam logic [16:0] FULL_TURN    = 17'd92160;
    localparam logic [16:0] QUARTER_TURN = 17'd23040;
    localparam logic [16:0] HALF_TURN    = 17'd46080;
    localparam logic [16:0] THREE_QUARTER = 17'd69120;
    localparam logic [16:0] RAD_K        = 17'd73204;
    localparam logic [21:0] ROT_OFFSET   = 22'd552960;
    localparam logic [10:0] RECIP_45     = 11'd1456;
    localparam logic [9:0]  TURN_HI      = 10'd45;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [51:0] ROUND_HALF   = 52'h20_0000_0000;

    typedef struct packed {
        logic               start;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [16:0]        sang;
        logic [2:0]         act;
        logic signed [19:0] opt;
        logic [23:0]        col;
    } cmd_t;

    // divisors of the nested sine series, innermost first
    function automatic logic [6:0] series_div(input logic [2:0] i);
        logic [6:0] d;
        case (i)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [29:0] series_recip(input logic [2:0] i);
        logic [29:0] m;
        case (i)
            3'd0:    m = 30'd39045157;
            3'd1:    m = 30'd59652323;
            3'd2:    m = 30'd102261126;
            3'd3:    m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tgi_front.sv
// ----------------------------------------------------------------------------
// tgi_front
// Holds the action entries, matches each symbol and builds a command.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_front #(
    parameter int ENTRY_COUNT = tgi_pkg::ENTRY_COUNT_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [tgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tgi_pkg::ENTRY_W-1:0]     cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [tgi_pkg::IN_W-1:0]        s_tdata,
    input  wire                             s_tuser,
    input  wire                             q_full,
    output logic                            q_push,
    output tgi_pkg::cmd_t                   q_cmd
);
    import tgi_pkg::*;

    logic [ENTRY_W-1:0] entry_reg [ENTRY_COUNT];
    logic [ENTRY_W-1:0] sel_entry;
    logic               hit;
    logic [16:0]        ang;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    entry_reg[i] <= cfg_data;
                end
            end
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        sel_entry = '0;
        hit       = 1'b0;
        for (int i = ENTRY_COUNT - 1; i >= 0; i--)
        begin
            if (entry_reg[i][7:0] == s_tdata[7:0])
            begin
                sel_entry = entry_reg[i];
                hit       = 1'b1;
            end
        end
    end

    always_comb
    begin
        ang = s_tdata[56:40];
        if (ang >= FULL_TURN)
        begin
            ang = ang - FULL_TURN;
        end
        q_cmd.start = s_tuser;
        q_cmd.sx    = s_tdata[23:8];
        q_cmd.sy    = s_tdata[39:24];
        q_cmd.sang  = ang;
        q_cmd.act   = hit ? sel_entry[10:8] : ACT_NONE;
        q_cmd.opt   = sel_entry[30:11];
        q_cmd.col   = sel_entry[54:31];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tgi_cmdq.sv
// ----------------------------------------------------------------------------
// tgi_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_cmdq (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  tgi_pkg::cmd_t  push_cmd,
    output logic           full,
    input  wire            pop,
    output logic           avail,
    output tgi_pkg::cmd_t  head
);
    import tgi_pkg::*;

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CMDQ_CW'(push) - CMDQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tgi_back.sv
// ----------------------------------------------------------------------------
// tgi_back
// Turtle state, save stack, sine series unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgi_back #(
    parameter int STACK_DEPTH = tgi_pkg::STACK_DEPTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_avail,
    input  tgi_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [tgi_pkg::OUT_W-1:0]    m_tdata,
    output logic [1:0]                   m_tuser
);
    import tgi_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_TRIG  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_MOVE  = 5'b10000
    } st_t;

    st_t                state_reg, state_next;
    logic signed [15:0] pos_x_reg, pos_x_next;
    logic signed [15:0] pos_y_reg, pos_y_next;
    logic [16:0]        heading_reg, heading_next;
    logic [23:0]        colour_reg, colour_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    logic [2:0]         act_reg, act_next;
    logic signed [19:0] opt_reg, opt_next;
    logic [23:0]        col_reg, col_next;
    logic [1:0]         quad_reg, quad_next;
    logic [14:0]        rem_reg, rem_next;
    logic               pass_reg, pass_next;
    logic [2:0]         step_reg, step_next;
    logic [2:0]         it_reg, it_next;
    logic [30:0]        x_reg, x_next;
    logic [31:0]        x2_reg, x2_next;
    logic [30:0]        t_reg, t_next;
    logic [31:0]        p_reg, p_next;
    logic [29:0]        e_reg, e_next;
    logic [30:0]        sr_reg, sr_next;
    logic [30:0]        cr_reg, cr_next;
    logic [12:0]        mc_reg, mc_next;
    logic [12:0]        ms_reg, ms_next;
    logic               cneg_reg, cneg_next;
    logic               sneg_reg, sneg_next;

    logic [STK_W-1:0]   stack_mem [STACK_DEPTH];
    logic [STK_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [STK_W-1:0]   mem_wd;

    logic               out_free;
    logic               emit;
    logic [1:0]         em_kind;
    logic signed [15:0] em_xf, em_yf, em_xt, em_yt;
    logic signed [19:0] em_rad;
    logic [23:0]        em_col;

    logic signed [15:0] eff_x, eff_y;
    logic [16:0]        eff_h;
    logic [23:0]        eff_col;
    logic [CW-1:0]      eff_cnt;
    logic [CW-1:0]      cnt_dec;

    logic [21:0]        rot_sum;
    logic [9:0]         rot_hi;
    logic [20:0]        rot_prod;
    logic [9:0]         rot_q45;
    logic [9:0]         rot_r;

    logic [14:0]        rr;
    logic [31:0]        x_prod;
    logic [61:0]        xx_prod;
    logic [62:0]        xt_prod;
    logic [61:0]        pm_prod;
    logic [36:0]        ed_prod;
    logic [37:0]        rem_div;
    logic [30:0]        qv;
    logic [61:0]        fin_prod;

    logic [30:0]        cmag, smag;
    logic               cneg, sneg;
    logic [19:0]        abs_opt;
    logic [51:0]        c_scaled, s_scaled;

    logic signed [17:0] sum_x, sum_y;
    logic signed [15:0] nx, ny;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    always_comb
    begin
        eff_x   = cmd.start ? cmd.sx : pos_x_reg;
        eff_y   = cmd.start ? cmd.sy : pos_y_reg;
        eff_h   = cmd.start ? cmd.sang : heading_reg;
        eff_col = cmd.start ? 24'd0 : colour_reg;
        eff_cnt = cmd.start ? '0 : count_reg;
        cnt_dec = eff_cnt - CW'(1);

        // heading + angle, reduced modulo a full turn as (hi mod 45) * 2048 + lo
        rot_sum  = 22'({5'd0, eff_h}) + 22'(signed'(cmd.opt)) + ROT_OFFSET;
        rot_hi   = rot_sum[20:11];
        rot_prod = rot_hi * RECIP_45;
        rot_q45  = 10'(rot_prod[20:16] * TURN_HI);
        rot_r    = rot_hi - rot_q45;
        if (rot_r >= TURN_HI)
        begin
            rot_r = rot_r - TURN_HI;
        end

        // sine series datapath
        rr       = pass_reg ? 15'(QUARTER_TURN - 17'(rem_reg)) : rem_reg;
        x_prod   = rr * RAD_K;
        xx_prod  = x_reg * x_reg;
        xt_prod  = x2_reg * t_reg;
        pm_prod  = p_reg * series_recip(it_reg);
        ed_prod  = e_reg * series_div(it_reg);
        rem_div  = 38'(p_reg) - 38'(ed_prod);
        qv       = 31'(e_reg) + 31'(rem_div >= 38'(series_div(it_reg)));
        fin_prod = x_reg * t_reg;

        case (quad_reg)
            2'd0:
            begin
                cmag = cr_reg; cneg = 1'b0; smag = sr_reg; sneg = 1'b0;
            end
            2'd1:
            begin
                cmag = sr_reg; cneg = 1'b1; smag = cr_reg; sneg = 1'b0;
            end
            2'd2:
            begin
                cmag = cr_reg; cneg = 1'b1; smag = sr_reg; sneg = 1'b1;
            end
            default:
            begin
                cmag = sr_reg; cneg = 1'b0; smag = cr_reg; sneg = 1'b1;
            end
        endcase
        abs_opt  = opt_reg[19] ? 20'(-opt_reg) : 20'(opt_reg);
        c_scaled = 52'(cmag * abs_opt) + ROUND_HALF;
        s_scaled = 52'(smag * abs_opt) + ROUND_HALF;

        sum_x = 18'(pos_x_reg) + (cneg_reg ? -18'(signed'({1'b0, mc_reg}))
                                           : 18'(signed'({1'b0, mc_reg})));
        sum_y = 18'(pos_y_reg) + (sneg_reg ? -18'(signed'({1'b0, ms_reg}))
                                           : 18'(signed'({1'b0, ms_reg})));
        if (sum_x > 18'sd32767)
        begin
            nx = 16'sh7fff;
        end
        else if (sum_x < -18'sd32768)
        begin
            nx = 16'sh8000;
        end
        else
        begin
            nx = sum_x[15:0];
        end
        if (sum_y > 18'sd32767)
        begin
            ny = 16'sh7fff;
        end
        else if (sum_y < -18'sd32768)
        begin
            ny = 16'sh8000;
        end
        else
        begin
            ny = sum_y[15:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        colour_next  = colour_reg;
        count_next   = count_reg;
        act_next     = act_reg;
        opt_next     = opt_reg;
        col_next     = col_reg;
        quad_next    = quad_reg;
        rem_next     = rem_reg;
        pass_next    = pass_reg;
        step_next    = step_reg;
        it_next      = it_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        t_next       = t_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        sr_next      = sr_reg;
        cr_next      = cr_reg;
        mc_next      = mc_reg;
        ms_next      = ms_reg;
        cneg_next    = cneg_reg;
        sneg_next    = sneg_reg;
        cmd_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = eff_cnt[AW-1:0];
        mem_ra       = cnt_dec[AW-1:0];
        mem_wd       = {eff_col, eff_h, eff_y, eff_x};
        emit         = 1'b0;
        em_kind      = KIND_LINE;
        em_xf        = '0;
        em_yf        = '0;
        em_xt        = '0;
        em_yt        = '0;
        em_rad       = '0;
        em_col       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail && out_free)
                begin
                    cmd_pop      = 1'b1;
                    pos_x_next   = eff_x;
                    pos_y_next   = eff_y;
                    heading_next = eff_h;
                    colour_next  = eff_col;
                    count_next   = eff_cnt;
                    case (cmd.act)
                        ACT_SAVE:
                        begin
                            if (eff_cnt == CW'(STACK_DEPTH))
                            begin
                                emit    = 1'b1;
                                em_kind = KIND_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = eff_cnt + CW'(1);
                            end
                        end
                        ACT_RESTORE:
                        begin
                            if (eff_cnt == '0)
                            begin
                                emit    = 1'b1;
                                em_kind = KIND_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                                state_next = ST_READ;
                            end
                        end
                        ACT_ROTATE:
                        begin
                            heading_next = {rot_r[5:0], rot_sum[10:0]};
                        end
                        ACT_CIRCLE:
                        begin
                            colour_next = cmd.col;
                            emit        = 1'b1;
                            em_kind     = KIND_CIRCLE;
                            em_xf       = eff_x;
                            em_yf       = eff_y;
                            em_rad      = cmd.opt;
                            em_col      = cmd.col;
                        end
                        ACT_DRAW, ACT_MOVE:
                        begin
                            act_next  = cmd.act;
                            opt_next  = cmd.opt;
                            col_next  = cmd.col;
                            pass_next = 1'b0;
                            step_next = 3'd0;
                            if (eff_h < QUARTER_TURN)
                            begin
                                quad_next = 2'd0;
                                rem_next  = eff_h[14:0];
                            end
                            else if (eff_h < HALF_TURN)
                            begin
                                quad_next = 2'd1;
                                rem_next  = 15'(eff_h - QUARTER_TURN);
                            end
                            else if (eff_h < THREE_QUARTER)
                            begin
                                quad_next = 2'd2;
                                rem_next  = 15'(eff_h - HALF_TURN);
                            end
                            else
                            begin
                                quad_next = 2'd3;
                                rem_next  = 15'(eff_h - THREE_QUARTER);
                            end
                            state_next = ST_TRIG;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                pos_x_next   = rd_data_reg[15:0];
                pos_y_next   = rd_data_reg[31:16];
                heading_next = rd_data_reg[48:32];
                colour_next  = rd_data_reg[72:49];
                state_next   = ST_IDLE;
            end
            ST_TRIG:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        x_next    = x_prod[30:0];
                        step_next = 3'd1;
                    end
                    3'd1:
                    begin
                        x2_next   = xx_prod[61:30];
                        t_next    = Q30_ONE;
                        it_next   = 3'd0;
                        step_next = 3'd2;
                    end
                    3'd2:
                    begin
                        p_next    = xt_prod[61:30];
                        step_next = 3'd3;
                    end
                    3'd3:
                    begin
                        e_next    = pm_prod[61:32];
                        step_next = 3'd4;
                    end
                    3'd4:
                    begin
                        t_next = Q30_ONE - qv;
                        if (it_reg == 3'd4)
                        begin
                            step_next = 3'd5;
                        end
                        else
                        begin
                            it_next   = it_reg + 3'd1;
                            step_next = 3'd2;
                        end
                    end
                    default:
                    begin
                        if (!pass_reg)
                        begin
                            sr_next   = fin_prod[60:30];
                            pass_next = 1'b1;
                            step_next = 3'd0;
                        end
                        else
                        begin
                            cr_next    = fin_prod[60:30];
                            state_next = ST_SCALE;
                        end
                    end
                endcase
            end
            ST_SCALE:
            begin
                mc_next    = c_scaled[50:38];
                ms_next    = s_scaled[50:38];
                cneg_next  = cneg ^ opt_reg[19];
                sneg_next  = sneg ^ opt_reg[19];
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (out_free || act_reg != ACT_DRAW)
                begin
                    pos_x_next = nx;
                    pos_y_next = ny;
                    if (act_reg == ACT_DRAW)
                    begin
                        colour_next = col_reg;
                        emit        = 1'b1;
                        em_kind     = KIND_LINE;
                        em_xf       = pos_x_reg;
                        em_yf       = pos_y_reg;
                        em_xt       = nx;
                        em_yt       = ny;
                        em_col      = col_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = em_kind;
            out_data_next  = {4'd0, em_col, em_rad, em_yt, em_xt, em_yf, em_xf};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            colour_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
            step_reg      <= '0;
            it_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            colour_reg    <= colour_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
            step_reg      <= step_next;
            it_reg        <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        act_reg      <= act_next;
        opt_reg      <= opt_next;
        col_reg      <= col_next;
        quad_reg     <= quad_next;
        rem_reg      <= rem_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        e_reg        <= e_next;
        sr_reg       <= sr_next;
        cr_reg       <= cr_next;
        mc_reg       <= mc_next;
        ms_reg       <= ms_next;
        cneg_reg     <= cneg_next;
        sneg_reg     <= sneg_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= stack_mem[mem_ra];
    end

endmodule

`default_nettype wire

>>> hw/rtl/turtle_graphics_interpreter.sv
// ----------------------------------------------------------------------------
// turtle_graphics_interpreter
// Streams symbols through a turtle and emits line and circle commands.
//
// Channels: s_* takes one symbol per transaction (tuser = start request),
// m_* gives one drawing or stack-error transaction, cfg_* writes one of the
// action entries by index. The front matches each symbol against the
// entries and queues a command; the back carries it out.
// Throughput: one symbol per cycle for save, restore of an empty stack,
// rotate, circle and unmatched symbols while the result output is free;
// a successful restore adds a registered stack read state; a forward move
// runs the shared sine-series unit (two passes of 18 steps) plus scale and
// add before the next symbol is taken. Each symbol is registered in the queue
// and each result in the output register; lines pass TRIG, SCALE, MOVE first.
// Reset: turtle at the origin, heading zero, colour black, stack empty,
// entries zero. The stack memory itself is not cleared.
// A stalled m_tready holds the result; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_graphics_interpreter #(
    parameter int STACK_DEPTH = tgi_pkg::STACK_DEPTH_DEF,
    parameter int ENTRY_COUNT = tgi_pkg::ENTRY_COUNT_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [tgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tgi_pkg::ENTRY_W-1:0]     cfg_data,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // symbol[7:0], start_x[23:8], start_y[39:24], start_angle[56:40]
    input  wire  [tgi_pkg::IN_W-1:0]        s_tdata,
    // start_req
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // x_from[15:0], y_from[31:16], x_to[47:32], y_to[63:48],
    // radius[83:64], colour[107:84]
    output logic [tgi_pkg::OUT_W-1:0]       m_tdata,
    // kind
    output logic [1:0]                      m_tuser
);
    import tgi_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_avail;

    tgi_front #(
        .ENTRY_COUNT(ENTRY_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    tgi_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (head_cmd)
    );

    tgi_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (q_avail),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
